>>> rtl/core/tkps_pkg.sv
// Shared types, constants and ordering function of the top-k priority selector.
package tkps_pkg;

    localparam int PRIO_W = 16;
    localparam int ID_W   = 32;
    localparam int KEEP_W = 5;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_rec;

    typedef struct packed {
        logic ins;    // write the offered record into the chain
        logic app;    // the insert grows the kept set by one
        logic shift;  // move every record one cell toward the head
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    // True when record a is emitted before record b.
    function automatic logic goes_first(t_rec a, t_rec b);
        return (a.prio != b.prio) ? (a.prio > b.prio) : (a.id < b.id);
    endfunction

endpackage

>>> rtl/core/top_k_priority_selector.sv
// Top level of the top-k priority selector: config register, cell chain and result register.
//
// Usage:
//   An item is a transfer on i_start while o_busy is low. i_operation selects
//   an offer (record i_priority_req / i_record_id) or a flush.
//   An offer is absorbed as it is transferred: every cell compares the record
//   with its own in parallel and the chain shifts by one to open the slot, so
//   offers may follow back to back at one per cycle while o_busy is low.
//   Offers never produce results. A flush raises o_busy while the chain shifts
//   toward the head, one record per cycle, until every kept record has left it.
//   Results are registered as they leave the head: o_strobe marks each for
//   exactly one cycle, highest priority first (ties by ascending id), o_last on
//   the final one. A flush of an empty store gives no result and no busy cycle.
//   The receiver cannot stall, so results are never held. o_busy is low again
//   in the cycle that shows the last result, so a new item may be transferred then.
//   i_cfg_we writes keep_count (effective count min(keep_count, MAX_KEPT)); write
//   it only while idle. Reset empties the store and sets keep_count to 16.
module top_k_priority_selector #(
    parameter int MAX_KEPT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_operation,
    input  logic [tkps_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [tkps_pkg::ID_W-1:0]    i_record_id,
    output logic                         o_busy,
    input  logic                         i_cfg_we,
    input  logic [tkps_pkg::KEEP_W-1:0]  i_cfg_wdata,
    output logic                         o_strobe,
    output logic [tkps_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [tkps_pkg::ID_W-1:0]    o_out_id,
    output logic                         o_last
);
    import tkps_pkg::*;

    logic [KEEP_W-1:0] r_keep_count;
    t_cell_ctl         w_ctl;
    t_rec              w_new;
    t_rec              w_rec      [MAX_KEPT];
    t_rec              w_prev_rec [MAX_KEPT];
    t_rec              w_next_rec [MAX_KEPT];
    logic [MAX_KEPT-1:0] w_valid;
    logic [MAX_KEPT-1:0] w_wins;
    logic [MAX_KEPT-1:0] w_gt;
    logic [MAX_KEPT-1:0] w_prev_valid;
    logic [MAX_KEPT-1:0] w_prev_wins;
    logic [MAX_KEPT-1:0] w_next_valid;
    logic [MAX_KEPT-1:0] w_is_min;
    logic              w_emit;
    logic              r_strobe;
    logic [PRIO_W-1:0] r_out_priority;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    assign w_new.prio = i_priority_req;
    assign w_new.id   = i_record_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_count <= KEEP_RESET;
        end else if (i_cfg_we) begin
            r_keep_count <= i_cfg_wdata;
        end
    end

    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_rec[g]   = '0;
            assign w_prev_valid[g] = 1'b1;
            assign w_prev_wins[g]  = 1'b0;
        end else begin : g_body
            assign w_prev_rec[g]   = w_rec[g-1];
            assign w_prev_valid[g] = w_valid[g-1];
            assign w_prev_wins[g]  = w_wins[g-1];
        end
        if (g == MAX_KEPT - 1) begin : g_tail
            assign w_next_rec[g]   = '0;
            assign w_next_valid[g] = 1'b0;
        end else begin : g_inner
            assign w_next_rec[g]   = w_rec[g+1];
            assign w_next_valid[g] = w_valid[g+1];
        end
        // the lowest-ranked kept record sits in the last valid cell
        assign w_is_min[g] = w_valid[g] && !w_next_valid[g] && w_gt[g];

        tkps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_prev_rec   (w_prev_rec[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_prev_wins  (w_prev_wins[g]),
            .i_next_rec   (w_next_rec[g]),
            .i_next_valid (w_next_valid[g]),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_wins       (w_wins[g]),
            .o_gt         (w_gt[g])
        );
    end

    tkps_ctrl #(
        .MAX_KEPT (MAX_KEPT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_operation    (i_operation),
        .i_keep_count   (r_keep_count),
        .i_head_valid   (w_valid[0]),
        .i_second_valid (w_next_valid[0]),
        .i_min_beaten   (|w_is_min),
        .o_ctl          (w_ctl),
        .o_busy         (o_busy),
        .o_emit         (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_priority <= w_rec[0].prio;
            r_out_id       <= w_rec[0].id;
            r_out_last     <= !w_next_valid[0];
        end
    end

    assign o_strobe       = r_strobe;
    assign o_out_priority = r_out_priority;
    assign o_out_id       = r_out_id;
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !o_busy)
        else $error("still busy after last result");
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("flush burst broken before last");
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_out_priority <= $past(o_out_priority)))
        else $error("flush results out of priority order");
`endif

endmodule

>>> rtl/core/tkps_cell.sv
// One cell of the sorted record chain: holds a record and trades it with its neighbors.
module tkps_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tkps_pkg::t_cell_ctl i_ctl,
    input  tkps_pkg::t_rec    i_new,
    input  tkps_pkg::t_rec    i_prev_rec,
    input  logic              i_prev_valid,
    input  logic              i_prev_wins,
    input  tkps_pkg::t_rec    i_next_rec,
    input  logic              i_next_valid,
    output tkps_pkg::t_rec    o_rec,
    output logic              o_valid,
    output logic              o_wins,
    output logic              o_gt
);
    import tkps_pkg::*;

    t_rec r_rec;
    t_rec n_rec;
    logic r_valid;
    logic n_valid;

    assign o_wins = !r_valid || goes_first(i_new, r_rec);
    assign o_gt   = r_valid && (i_new.prio > r_rec.prio);
    assign o_rec  = r_rec;
    assign o_valid = r_valid;

    always_comb begin
        n_rec   = r_rec;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_rec   = i_next_rec;
            n_valid = i_next_valid;
        end else if (i_ctl.ins) begin
            if (i_prev_wins) begin
                n_rec = i_prev_rec;
            end else if (o_wins) begin
                n_rec = i_new;
            end
            if (i_ctl.app) begin
                n_valid = r_valid | i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

>>> rtl/core/tkps_ctrl.sv
// Control of the selector: offer decision, kept count and flush sequencing.
module tkps_ctrl #(
    parameter int MAX_KEPT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_operation,
    input  logic [tkps_pkg::KEEP_W-1:0]  i_keep_count,
    input  logic                         i_head_valid,
    input  logic                         i_second_valid,
    input  logic                         i_min_beaten,
    output tkps_pkg::t_cell_ctl          o_ctl,
    output logic                         o_busy,
    output logic                         o_emit
);
    import tkps_pkg::*;

    localparam int TW = $clog2(MAX_KEPT + 1);
    localparam int KW = (TW > KEEP_W) ? TW : KEEP_W;

    t_state r_state;
    t_state n_state;
    logic [TW-1:0] r_total;
    logic [TW-1:0] n_total;
    logic [KW-1:0] w_keep;
    logic [KW-1:0] w_max;
    logic [KW-1:0] w_k;
    logic [KW-1:0] w_total;
    logic          w_append_ok;
    logic          w_replace_ok;
    logic          w_take;

    assign w_keep  = KW'(i_keep_count);
    assign w_max   = KW'(MAX_KEPT);
    assign w_k     = (w_keep > w_max) ? w_max : w_keep;
    assign w_total = KW'(r_total);
    assign w_append_ok  = (w_k != '0) && (w_total < w_k);
    assign w_replace_ok = (w_k != '0) && (w_total >= w_k) && (r_total != '0) && i_min_beaten;
    assign w_take = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && (i_operation == OP_FLUSH) && i_head_valid) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_second_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_busy  = 1'b0;
        o_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ins = w_take && (i_operation == OP_OFFER) && (w_append_ok || w_replace_ok);
                o_ctl.app = w_take && (i_operation == OP_OFFER) && w_append_ok;
            end
            ST_FLUSH: begin
                o_busy      = 1'b1;
                o_emit      = 1'b1;
                o_ctl.shift = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

    always_comb begin
        n_total = r_total;
        if (w_take && (i_operation == OP_FLUSH)) begin
            n_total = '0;
        end else if (o_ctl.app) begin
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
        end
    end

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_total) <= w_max)
        else $error("kept count above capacity");
    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.app |=> (r_total == $past(r_total) + 1'b1))
        else $error("append did not grow kept count");
    a_flush_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && (i_operation == OP_FLUSH)))
        else $error("flush entered without flush transfer");
`endif

endmodule

>>> tb/top_k_checker.sv
// Checker for the top-k priority selector: tracks the kept store, predicts flush output, compares.
module top_k_checker #(
    parameter int KEPT_LIMIT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_operation,
    input  logic [tkps_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [tkps_pkg::ID_W-1:0]    i_record_id,
    input  logic                         i_busy,
    input  logic                         i_cfg_we,
    input  logic [tkps_pkg::KEEP_W-1:0]  i_cfg_wdata,
    input  logic                         i_strobe,
    input  logic [tkps_pkg::PRIO_W-1:0]  i_out_priority,
    input  logic [tkps_pkg::ID_W-1:0]    i_out_id,
    input  logic                         i_last,
    output int                           o_mismatches,
    output int                           o_outstanding,
    output int                           o_records
);
    import tkps_pkg::*;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic              last;
    } t_emitted;

    t_rec              kept [KEPT_LIMIT];
    int                kept_num;
    logic [KEEP_W-1:0] keep_setting;
    t_emitted          flush_order_q[$];
    int                mismatches;
    int                records;

    assign o_mismatches = mismatches;
    assign o_records    = records;

    // a leaves the store ahead of b
    function automatic logic ranks_ahead(t_rec a, t_rec b);
        if (a.prio != b.prio) begin
            return a.prio > b.prio;
        end
        return a.id < b.id;
    endfunction

    task automatic absorb_offer(t_rec r);
        int k;
        int m;
        k = (keep_setting > KEPT_LIMIT) ? KEPT_LIMIT : int'(keep_setting);
        if (k == 0) begin
            return;
        end
        if (kept_num < k && kept_num < KEPT_LIMIT) begin
            kept[kept_num] = r;
            kept_num++;
            return;
        end
        if (kept_num == 0) begin
            return;
        end
        m = 0;
        for (int i = 1; i < kept_num; i++) begin
            if (ranks_ahead(kept[m], kept[i])) begin
                m = i;
            end
        end
        if (r.prio > kept[m].prio) begin
            kept[m] = r;
        end
    endtask

    task automatic drain_store();
        t_rec     sorted [KEPT_LIMIT];
        t_rec     hold;
        t_emitted e;
        int       j;
        for (int i = 0; i < kept_num; i++) begin
            sorted[i] = kept[i];
        end
        for (int i = 1; i < kept_num; i++) begin
            hold = sorted[i];
            j = i;
            while (j > 0 && ranks_ahead(hold, sorted[j-1])) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = hold;
        end
        for (int i = 0; i < kept_num; i++) begin
            e.prio = sorted[i].prio;
            e.id   = sorted[i].id;
            e.last = (i == kept_num - 1);
            flush_order_q.push_back(e);
        end
        kept_num = 0;
    endtask

    task automatic note_mismatch(string what, t_emitted want, t_emitted got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected prio=%0h id=%0h last=%0b, got prio=%0h id=%0h last=%0b",
                     what, want.prio, want.id, want.last, got.prio, got.id, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_emitted got;
        t_emitted want;
        t_rec     offered;
        if (!i_rst_n) begin
            kept_num     = 0;
            keep_setting = KEEP_RESET;
            flush_order_q.delete();
        end else begin
            if (i_strobe) begin
                records++;
                got.prio = i_out_priority;
                got.id   = i_out_id;
                got.last = i_last;
                if (flush_order_q.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = flush_order_q.pop_front();
                    if (got !== want) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                keep_setting = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                if (i_operation == OP_FLUSH) begin
                    drain_store();
                end else begin
                    offered.prio = i_priority_req;
                    offered.id   = i_record_id;
                    absorb_offer(offered);
                end
            end
        end
        o_outstanding <= flush_order_q.size();
    end

    initial begin
        mismatches    = 0;
        records       = 0;
        kept_num      = 0;
        keep_setting  = KEEP_RESET;
        o_outstanding = 0;
    end

endmodule

>>> tb/testbench.sv
// Top of the top-k priority selector testbench: clock, reset, stimulus and verdict.
module testbench;
    import tkps_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              operation;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   rec_id;
    logic              busy;
    logic              cfg_we;
    logic [KEEP_W-1:0] cfg_wdata;
    logic              strobe;
    logic [PRIO_W-1:0] out_prio;
    logic [ID_W-1:0]   out_id;
    logic              last;

    int mismatches;
    int outstanding;
    int records;
    int items_sent;
    int flushes_sent;
    int keep_writes;

    top_k_priority_selector #(
        .MAX_KEPT(16)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_operation    (operation),
        .i_priority_req (prio),
        .i_record_id    (rec_id),
        .o_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_strobe       (strobe),
        .o_out_priority (out_prio),
        .o_out_id       (out_id),
        .o_last         (last)
    );

    top_k_checker #(
        .KEPT_LIMIT(16)
    ) selector_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_operation    (operation),
        .i_priority_req (prio),
        .i_record_id    (rec_id),
        .i_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_strobe       (strobe),
        .i_out_priority (out_prio),
        .i_out_id       (out_id),
        .i_last         (last),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_records      (records)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // holds start high until the transfer goes through
    task automatic send(logic op, logic [PRIO_W-1:0] p, logic [ID_W-1:0] r);
        start     <= 1'b1;
        operation <= op;
        prio      <= p;
        rec_id    <= r;
        do @(posedge clk); while (busy);
        items_sent++;
        if (op == OP_FLUSH) begin
            flushes_sent++;
        end
    endtask

    task automatic pause(int n);
        if (n == 0) begin
            return;
        end
        start     <= 1'b0;
        operation <= 1'($urandom_range(0, 1));
        prio      <= PRIO_W'($urandom);
        rec_id    <= $urandom;
        repeat (n) @(posedge clk);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // wait until no results are pending, with start held low
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_keep(logic [KEEP_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        keep_writes++;
    endtask

    function automatic logic [PRIO_W-1:0] rand_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return PRIO_W'($urandom_range(0, 7));
        end
        if (r < 60) begin
            return r[0] ? 16'hffff : 16'h0000;
        end
        return PRIO_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        if ($urandom_range(0, 1)) begin
            return $urandom_range(0, 3);
        end
        return $urandom;
    endfunction

    initial begin
        logic [KEEP_W-1:0] keep_plan [8];
        int                phase;
        int                bursts;
        int                n;
        keep_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd7, 5'd2, 5'd16};
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_OFFER;
        prio         = '0;
        rec_id       = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        items_sent   = 0;
        flushes_sent = 0;
        keep_writes  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default keep count, empty flush, field extremes
        send(OP_FLUSH, 16'h0, 32'h0);
        send(OP_OFFER, 16'h0000, 32'h0000_0000);
        send(OP_OFFER, 16'hffff, 32'hffff_ffff);
        send(OP_OFFER, 16'hffff, 32'h0000_0000);
        send(OP_OFFER, 16'h0000, 32'hffff_ffff);
        send(OP_OFFER, 16'h1234, 32'h0000_0005);
        send(OP_FLUSH, 16'h0, 32'h0);

        // small store: equal-priority offer dropped, strictly greater replaces
        write_keep(5'd2);
        send(OP_OFFER, 16'd100, 32'd7);
        send(OP_OFFER, 16'd100, 32'd3);
        send(OP_OFFER, 16'd100, 32'd9);
        send(OP_OFFER, 16'd101, 32'd1);
        send(OP_FLUSH, 16'h0, 32'h0);

        // zero keep count drops everything
        write_keep(5'd0);
        send(OP_OFFER, 16'hffff, 32'd1);
        send(OP_OFFER, 16'd5, 32'd2);
        send(OP_FLUSH, 16'h0, 32'h0);

        // keep count lowered below what is already kept
        write_keep(5'd5);
        for (int i = 0; i < 5; i++) begin
            send(OP_OFFER, 16'(10 + i), 32'(i));
        end
        write_keep(5'd2);
        send(OP_OFFER, 16'd50, 32'd77);
        send(OP_OFFER, 16'd11, 32'd88);
        send(OP_FLUSH, 16'h0, 32'h0);

        phase = 0;
        while (items_sent < 240) begin
            write_keep(phase < 8 ? keep_plan[phase] : KEEP_W'($urandom_range(0, 31)));
            phase++;
            bursts = $urandom_range(2, 5);
            for (int b = 0; b < bursts && items_sent < 250; b++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
                for (int i = 0; i < n; i++) begin
                    send(OP_OFFER, rand_prio(), rand_id());
                    pause(gap_len());
                end
                if ($urandom_range(0, 99) < 85) begin
                    send(OP_FLUSH, PRIO_W'($urandom), $urandom);
                    pause(gap_len());
                end
            end
        end
        send(OP_FLUSH, PRIO_W'($urandom), $urandom);
        settle();
        repeat (20) @(posedge clk);

        $display("Sent %0d items (%0d flushes) over %0d keep-count writes;",
                 items_sent, flushes_sent, keep_writes);
        $display("%0d records checked against the predicted flush order.", records);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tkps_pkg.sv
rtl/core/tkps_cell.sv
rtl/core/tkps_ctrl.sv
rtl/core/top_k_priority_selector.sv
tb/top_k_checker.sv
tb/testbench.sv
